// ----- rtl/gpio_eqd_pkg.sv -----
// Shared types, constants and field layouts for the GPIO edge event queue.
// No dependencies; every other file in rtl/ except gpio_eqd_ram refers to this package by scope.
package gpio_eqd_pkg;

   // Parameter defaults
   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int PIN_COUNT_DEF   = 48;

   // Field widths
   localparam int KIND_W  = 2;
   localparam int PIN_W   = 6;
   localparam int EDGE_W  = 2;
   localparam int DEB_W   = 16;
   localparam int TIME_W  = 32;
   localparam int MS_W    = 23;
   localparam int PEND_W  = 5;
   localparam int DROP_W  = 32;
   localparam int WIN_W   = 26;   // 65535 * 1000 fits in 26 bits

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 72;

   // Window scale and divide-by-1000 reciprocal: q = (n * DIV_MAGIC) >> DIV_SHIFT
   localparam int US_PER_MS  = 1000;
   localparam int DIV_MAGIC  = 274877907;
   localparam int DIV_SHIFT  = 38;
   localparam int DIV_PROD_W = 61;

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_EDGE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WATCH = 2'd1;
   localparam logic [KIND_W-1:0] KIND_POP   = 2'd2;

   // Edge bit positions
   localparam int EDGE_RISE = 1;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [EDGE_W-1:0] enable;
      logic [WIN_W-1:0]  window_us;
      logic [TIME_W-1:0] last_us;
   } pin_entry_type;

   localparam int PIN_ENTRY_W = $bits(pin_entry_type);

   typedef struct packed {
      logic [MS_W-1:0]  ms;
      logic             level;
      logic [PIN_W-1:0] pin;
   } event_type;

   localparam int EVENT_W = $bits(event_type);

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctl_type;

   typedef struct packed {
      logic              empty;
      logic [PEND_W-1:0] pending;
      logic [DROP_W-1:0] dropped;
   } queue_stat_type;

endpackage

// ----- rtl/gpio_eqd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gpio_eqd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/gpio_eqd_pin_table.sv -----
// Per-pin table: enables, debounce window and last accepted time in one RAM.
// Depends on gpio_eqd_pkg and gpio_eqd_ram; valid bits make unwritten rows read zero.
module gpio_eqd_pin_table #(
   parameter int PIN_COUNT = gpio_eqd_pkg::PIN_COUNT_DEF
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              rd_en,
   input  logic [((PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1)-1:0] rd_addr,
   output gpio_eqd_pkg::pin_entry_type                       rd_entry,
   input  logic                                              wr_en,
   input  logic [((PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1)-1:0] wr_addr,
   input  gpio_eqd_pkg::pin_entry_type                       wr_entry
);

   localparam int PAW = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

   logic [PIN_COUNT-1:0]                  valid_ff;
   logic                                  hit_ff;
   logic                                  hit_in;
   logic [gpio_eqd_pkg::PIN_ENTRY_W-1:0]  ram_q;

   gpio_eqd_ram #(
      .WIDTH (gpio_eqd_pkg::PIN_ENTRY_W),
      .DEPTH (PIN_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // Capture the row's valid bit alongside the RAM read
   assign hit_in = ({1'b0, rd_addr} < (PAW + 1)'(PIN_COUNT)) ? valid_ff[rd_addr] : 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            hit_ff <= hit_in;
         end
      end
   end

   assign rd_entry = hit_ff ? gpio_eqd_pkg::pin_entry_type'(ram_q) : '0;

endmodule

// ----- rtl/gpio_eqd_event_queue.sv -----
// Event queue: circular buffer in a RAM, with pointers, fill count and drop counter.
// Depends on gpio_eqd_pkg and gpio_eqd_ram.
module gpio_eqd_event_queue #(
   parameter int DEPTH = gpio_eqd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_rd,
   input  gpio_eqd_pkg::queue_ctl_type  ctl,
   input  gpio_eqd_pkg::event_type      push_data,
   output gpio_eqd_pkg::event_type      head,
   output gpio_eqd_pkg::queue_stat_type stat
);

   localparam int QAW    = $clog2(DEPTH);
   localparam int PEND_W = gpio_eqd_pkg::PEND_W;
   localparam int DROP_W = gpio_eqd_pkg::DROP_W;

   logic [QAW-1:0]                    wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]                    rd_ptr_ff, rd_ptr_in;
   logic [DROP_W-1:0]                 drop_ff, drop_in;
   logic [QAW-1:0]                    wr_nxt, rd_nxt;
   logic                              full, empty;
   logic                              do_push, do_drop, do_pop;
   logic [QAW:0]                      count;
   logic [gpio_eqd_pkg::EVENT_W-1:0]  head_bits;

   assign wr_nxt = (wr_ptr_ff == QAW'(DEPTH - 1)) ? '0 : wr_ptr_ff + QAW'(1);
   assign rd_nxt = (rd_ptr_ff == QAW'(DEPTH - 1)) ? '0 : rd_ptr_ff + QAW'(1);

   // One slot stays empty to tell full from empty
   assign full  = (wr_nxt == rd_ptr_ff);
   assign empty = (wr_ptr_ff == rd_ptr_ff);

   assign do_push = ctl.push && !full;
   assign do_drop = ctl.push && full;
   assign do_pop  = ctl.pop && !empty;

   assign wr_ptr_in = do_push ? wr_nxt : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_nxt : rd_ptr_ff;
   assign drop_in   = do_drop ? drop_ff + DROP_W'(1) : drop_ff;

   // Fill level after this update
   assign count = (wr_ptr_in >= rd_ptr_in)
                ? {1'b0, wr_ptr_in} - {1'b0, rd_ptr_in}
                : {1'b0, wr_ptr_in} + (QAW + 1)'(DEPTH) - {1'b0, rd_ptr_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         drop_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         drop_ff   <= drop_in;
      end
   end

   gpio_eqd_ram #(
      .WIDTH (gpio_eqd_pkg::EVENT_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (wr_ptr_ff),
      .wr_data (push_data),
      .rd_en   (head_rd),
      .rd_addr (rd_ptr_ff),
      .rd_data (head_bits)
   );

   assign head          = gpio_eqd_pkg::event_type'(head_bits);
   assign stat.empty    = empty;
   assign stat.pending  = PEND_W'(count);
   assign stat.dropped  = drop_in;

endmodule

// ----- rtl/gpio_edge_event_queue_debounce.sv -----
// Top level: GPIO edge watcher with per-pin debounce and an event queue.
// Depends on gpio_eqd_pkg, gpio_eqd_pin_table and gpio_eqd_event_queue.
//
// Channel  Dir  Handshake           Payload
// req      in   req_tvalid/tready   tuser: kind; tdata: pin, edge_bits, settle_ms, now_us
// rsp      out  rsp_tvalid/tready   tuser: event_valid; tdata: event_pin, event_level,
//                                   event_ms, pending, dropped, bad_pin
//
// Each item is accepted in the idle state, which issues the reads of the pin table
// row and the queue head; the execute state decides, writes both RAMs back and
// loads the result register. One item is in flight at a time; the next one is
// accepted while the previous result still waits in the output register.
// A result still held at the output stalls the execute state until it is taken.
// Reset is synchronous and needs no clearing pass: pin table rows read as zero
// until first written, and queue entries are read only after being written.
module gpio_edge_event_queue_debounce #(
   parameter int QUEUE_DEPTH = gpio_eqd_pkg::QUEUE_DEPTH_DEF,
   parameter int PIN_COUNT   = gpio_eqd_pkg::PIN_COUNT_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // [5:0] pin, [7:6] edge_bits, [23:8] settle_ms, [55:24] now_us
   input  logic [gpio_eqd_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [1:0] kind
   input  logic [gpio_eqd_pkg::KIND_W-1:0]        req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [5:0] event_pin, [6] event_level, [29:7] event_ms, [34:30] pending,
   // [66:35] dropped, [67] bad_pin, [71:68] zero
   output logic [gpio_eqd_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // [0] event_valid
   output logic                                   rsp_tuser
);

   localparam int PAW        = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
   localparam int PIN_W      = gpio_eqd_pkg::PIN_W;
   localparam int EDGE_W     = gpio_eqd_pkg::EDGE_W;
   localparam int DEB_W      = gpio_eqd_pkg::DEB_W;
   localparam int TIME_W     = gpio_eqd_pkg::TIME_W;
   localparam int MS_W       = gpio_eqd_pkg::MS_W;
   localparam int WIN_W      = gpio_eqd_pkg::WIN_W;
   localparam int DIV_PROD_W = gpio_eqd_pkg::DIV_PROD_W;
   localparam int RSP_W      = gpio_eqd_pkg::RSP_TDATA_W;
   localparam int RSP_USED_W = gpio_eqd_pkg::EVENT_W + gpio_eqd_pkg::PEND_W
                             + gpio_eqd_pkg::DROP_W + 1;

   // Item fields, held for the execute cycle
   logic [gpio_eqd_pkg::KIND_W-1:0] kind_ff;
   logic [PIN_W-1:0]                pin_ff;
   logic [EDGE_W-1:0]               edges_ff;
   logic [DEB_W-1:0]                deb_ff;
   logic [TIME_W-1:0]               now_ff;

   gpio_eqd_pkg::state_type         state_ff, state_in;
   logic                            accept;
   logic                            commit;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]                rsp_data_ff, rsp_data_in;
   logic                            rsp_user_ff, rsp_user_in;

   gpio_eqd_pkg::pin_entry_type     entry;
   gpio_eqd_pkg::pin_entry_type     entry_wr;
   logic                            entry_we;
   gpio_eqd_pkg::event_type         head;
   gpio_eqd_pkg::event_type         new_event;
   gpio_eqd_pkg::event_type         out_event;
   gpio_eqd_pkg::queue_ctl_type     qctl;
   gpio_eqd_pkg::queue_stat_type    qstat;

   logic                            pin_ok;
   logic                            is_edge, is_watch, is_pop;
   logic [EDGE_W-1:0]               masked;
   logic [TIME_W-1:0]               elapsed;
   logic                            in_window;
   logic                            edge_take;
   logic                            pop_ok;
   logic                            bad_pin;
   logic [WIN_W-1:0]                win_new;
   logic [DIV_PROD_W-1:0]           div_prod;

   assign accept = req_tvalid && req_tready;

   // ---------------------------------------------------------------------------
   // Sequencer: idle (accept, issue reads) then execute (write back, load result)
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gpio_eqd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      commit     = 1'b0;
      case (state_ff)
         gpio_eqd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = gpio_eqd_pkg::ST_EXEC;
            end
         end
         gpio_eqd_pkg::ST_EXEC: begin
            // Hold until the output register has room
            if (!rsp_valid_ff || rsp_tready) begin
               commit   = 1'b1;
               state_in = gpio_eqd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gpio_eqd_pkg::ST_IDLE;
         end
      endcase
   end

   // Capture the item fields
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_tuser;
         pin_ff   <= req_tdata[0 +: PIN_W];
         edges_ff <= req_tdata[PIN_W +: EDGE_W];
         deb_ff   <= req_tdata[PIN_W + EDGE_W +: DEB_W];
         now_ff   <= req_tdata[PIN_W + EDGE_W + DEB_W +: TIME_W];
      end
   end

   // ---------------------------------------------------------------------------
   // Pin table: read on accept, write back on commit
   // ---------------------------------------------------------------------------
   gpio_eqd_pin_table #(
      .PIN_COUNT (PIN_COUNT)
   ) u_pin_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (req_tdata[PAW-1:0]),
      .rd_entry (entry),
      .wr_en    (entry_we),
      .wr_addr  (pin_ff[PAW-1:0]),
      .wr_entry (entry_wr)
   );

   // ---------------------------------------------------------------------------
   // Decide
   // ---------------------------------------------------------------------------
   assign pin_ok   = ({1'b0, pin_ff} < (PIN_W + 1)'(PIN_COUNT));
   assign is_edge  = (kind_ff == gpio_eqd_pkg::KIND_EDGE);
   assign is_watch = (kind_ff == gpio_eqd_pkg::KIND_WATCH);
   assign is_pop   = (kind_ff == gpio_eqd_pkg::KIND_POP);
   assign bad_pin  = (is_edge || is_watch) && !pin_ok;

   assign masked    = edges_ff & entry.enable;
   // Elapsed time wraps modulo 2^32
   assign elapsed   = now_ff - entry.last_us;
   assign in_window = (entry.window_us != '0) && (elapsed < TIME_W'(entry.window_us));
   assign edge_take = is_edge && pin_ok && (masked != '0) && !in_window;

   assign pop_ok = is_pop && !qstat.empty;

   // Window in microseconds: 16 x 10 bit multiply
   assign win_new  = WIN_W'(deb_ff) * WIN_W'(gpio_eqd_pkg::US_PER_MS);

   // Milliseconds by reciprocal multiply, exact for every 32-bit time
   assign div_prod = DIV_PROD_W'(now_ff) * DIV_PROD_W'(gpio_eqd_pkg::DIV_MAGIC);

   // Row write-back: accepted edge records its time; watch rewrites enables and window
   always_comb begin
      entry_wr = entry;
      entry_we = 1'b0;
      if (commit && edge_take) begin
         entry_we        = 1'b1;
         entry_wr.last_us = now_ff;
      end else if (commit && is_watch && pin_ok) begin
         entry_we = 1'b1;
         if (edges_ff == '0) begin
            // Watch off: keep the last accepted time
            entry_wr.enable    = '0;
            entry_wr.window_us = '0;
         end else begin
            entry_wr.enable    = edges_ff;
            entry_wr.window_us = win_new;
            entry_wr.last_us   = '0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Event queue
   // ---------------------------------------------------------------------------
   assign new_event.pin   = pin_ff;
   assign new_event.level = masked[gpio_eqd_pkg::EDGE_RISE];   // rise wins
   assign new_event.ms    = div_prod[gpio_eqd_pkg::DIV_SHIFT +: MS_W];

   assign qctl.push = commit && edge_take;
   assign qctl.pop  = commit && is_pop;

   gpio_eqd_event_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .head_rd   (accept),
      .ctl       (qctl),
      .push_data (new_event),
      .head      (head),
      .stat      (qstat)
   );

   // ---------------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------------
   assign out_event   = pop_ok ? head : '0;
   assign rsp_data_in = {(RSP_W - RSP_USED_W)'(0), bad_pin, qstat.dropped,
                         qstat.pending, out_event};
   assign rsp_user_in = pop_ok;

   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- rtl/gpio_eqd_checker.sv -----
// Port-level checks for the GPIO edge event queue, bound to the top level.
// Depends on gpio_eqd_pkg and gpio_edge_event_queue_debounce.
module gpio_eqd_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [gpio_eqd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                                 rsp_tuser
);

   localparam int BAD_BIT = gpio_eqd_pkg::EVENT_W + gpio_eqd_pkg::PEND_W
                          + gpio_eqd_pkg::DROP_W;

   // One item in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while previous item still executing");

   // Event fields read zero when no event was popped
   a_event_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[gpio_eqd_pkg::EVENT_W-1:0] == '0))
      else $error("event fields nonzero without an event");

   // A popped event never carries the bad pin flag
   a_pop_not_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser && rsp_tdata[BAD_BIT]))
      else $error("event and bad pin flagged together");

   // Held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind gpio_edge_event_queue_debounce gpio_eqd_checker u_checker (.*);
